>>> hdl/kfcv_pkg.sv
// Package for the constant-velocity Kalman filter: widths, state codes,
// the multiply-divide handshake types and saturating arithmetic helpers.
// Used by kfcv_muldiv and kalman_filter_const_velocity; depends on nothing.
package kfcv_pkg;

    localparam int STATE_WIDTH = 32;
    localparam int COV_WIDTH   = 48;

    localparam logic signed [63:0] STATE_MAX = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] COV_MAX   = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;

    // Diagonal covariance after reset: 1000.0 in Q24.24.
    localparam logic signed [COV_WIDTH-1:0] COV_RESET = COV_WIDTH'(64'sd1000 <<< 24);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TIME_STEP     = 3'd0,
        CFG_MEAS_NOISE    = 3'd1,
        CFG_Q_POS         = 3'd2,
        CFG_Q_CROSS       = 3'd3,
        CFG_Q_VEL         = 3'd4,
        CFG_MOTION_POS    = 3'd5,
        CFG_MOTION_VEL    = 3'd6,
        CFG_INIT_VARIANCE = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INNOV,
        ST_ISSUE,
        ST_WAIT,
        ST_UPD,
        ST_PRED,
        ST_OUT
    } t_state;

    // Multiply-divide operations of one measurement command, in issue order.
    typedef enum logic [3:0] {
        OP_K00,
        OP_K01,
        OP_K10,
        OP_K11,
        OP_KX0,
        OP_KX1,
        OP_DX,
        OP_DP10,
        OP_DP11,
        OP_DA01
    } t_op;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_FIN
    } t_md_state;

    typedef struct packed {
        logic start;
        logic shift;
    } t_md_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_md_rsp;

    typedef struct packed {
        logic              sat;
        logic signed [63:0] v;
    } t_sres;

    function automatic t_sres f_sadd(input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [64:0] sum;
        t_sres r;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            r.sat = 1'b1;
            r.v   = sum[64] ? S64_MIN : S64_MAX;
        end else begin
            r.sat = 1'b0;
            r.v   = sum[63:0];
        end
        return r;
    endfunction

    function automatic t_sres f_ssub(input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [64:0] dif;
        t_sres r;
        dif = {a[63], a} - {b[63], b};
        if (dif[64] != dif[63]) begin
            r.sat = 1'b1;
            r.v   = dif[64] ? S64_MIN : S64_MAX;
        end else begin
            r.sat = 1'b0;
            r.v   = dif[63:0];
        end
        return r;
    endfunction

    function automatic t_sres f_clamp(input logic signed [63:0] v, input logic signed [63:0] hi);
        logic signed [63:0] lo;
        t_sres r;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            r.sat = 1'b1;
            r.v   = hi;
        end else if (v < lo) begin
            r.sat = 1'b1;
            r.v   = lo;
        end else begin
            r.sat = 1'b0;
            r.v   = v;
        end
        return r;
    endfunction

endpackage

>>> hdl/kfcv_muldiv.sv
// Shared multiply-divide unit: (a*b)/d truncated toward zero, saturated to 64 bits.
// Four 32x32 partial products, then a restoring divide one bit per cycle,
// or a 16-bit shift in shift mode. Depends on kfcv_pkg.
module kfcv_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kfcv_pkg::t_md_req  i_req,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic        [63:0] i_div,
    output kfcv_pkg::t_md_rsp  o_rsp,
    output logic signed [63:0] o_result
);

    kfcv_pkg::t_md_state r_state, n_state;
    logic [5:0]   r_cnt;
    logic [63:0]  r_ma, r_mb, r_d;
    logic         r_neg, r_shift, r_ovf;
    logic [127:0] r_acc;

    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [127:0] addend;
    logic [63:0]  shifted, q;
    logic         carry, ge;

    always_comb begin
        ah = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        bh = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        pp = 64'(ah) * 64'(bh);
        unique case (r_cnt[1:0])
            2'd0:       addend = {64'd0, pp};
            2'd1, 2'd2: addend = {32'd0, pp, 32'd0};
            default:    addend = {pp, 64'd0};
        endcase
        carry   = r_acc[127];
        shifted = {r_acc[126:64], r_acc[63]};
        ge      = carry || (shifted >= r_d);
        q       = r_acc[63:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kfcv_pkg::MD_IDLE: if (i_req.start) n_state = kfcv_pkg::MD_MUL;
            kfcv_pkg::MD_MUL:  if (r_cnt[1:0] == 2'd3) n_state = kfcv_pkg::MD_CHK;
            kfcv_pkg::MD_CHK: begin
                if (r_shift || r_acc[127:64] >= r_d) n_state = kfcv_pkg::MD_FIN;
                else n_state = kfcv_pkg::MD_DIV;
            end
            kfcv_pkg::MD_DIV:  if (r_cnt == 6'd63) n_state = kfcv_pkg::MD_FIN;
            kfcv_pkg::MD_FIN:  n_state = kfcv_pkg::MD_IDLE;
            default:           n_state = kfcv_pkg::MD_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == kfcv_pkg::MD_FIN);
        o_rsp.sat  = r_ovf | q[63];
        if (o_rsp.sat) o_result = r_neg ? kfcv_pkg::S64_MIN : kfcv_pkg::S64_MAX;
        else o_result = r_neg ? -$signed(q) : $signed(q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfcv_pkg::MD_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                kfcv_pkg::MD_IDLE: begin
                    r_ma    <= i_a[63] ? 64'(-i_a) : i_a;
                    r_mb    <= i_b[63] ? 64'(-i_b) : i_b;
                    r_neg   <= i_a[63] != i_b[63];
                    r_shift <= i_req.shift;
                    r_d     <= i_div;
                    r_acc   <= 128'd0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= 6'd0;
                end
                kfcv_pkg::MD_MUL: begin
                    r_acc <= r_acc + addend;
                    r_cnt <= (r_cnt[1:0] == 2'd3) ? 6'd0 : r_cnt + 6'd1;
                end
                kfcv_pkg::MD_CHK: begin
                    if (r_shift) begin
                        r_acc[63:0] <= r_acc[79:16];
                        r_ovf       <= |r_acc[127:80];
                    end else if (r_acc[127:64] >= r_d) begin
                        r_acc[63:0] <= 64'd0;
                        r_ovf       <= 1'b1;
                    end
                end
                kfcv_pkg::MD_DIV: begin
                    // The quotient bits shift into the low half as the dividend leaves it.
                    r_acc <= {ge ? shifted - r_d : shifted, r_acc[62:0], ge};
                    r_cnt <= r_cnt + 6'd1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfcv_pkg::MD_DIV) |-> (r_d != 64'd0))
        else $error("divide started with a zero divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfcv_pkg::MD_FIN) |=> (r_state == kfcv_pkg::MD_IDLE))
        else $error("result not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfcv_pkg::MD_CHK) |-> $past(r_state == kfcv_pkg::MD_MUL))
        else $error("check entered without multiply");

endmodule

>>> hdl/kalman_filter_const_velocity.sv
// Top level of the two-state constant-velocity Kalman filter.
// Holds the configuration registers, the estimate and covariance, and the
// sequencer that drives kfcv_muldiv. Depends on kfcv_pkg and kfcv_muldiv.
//
// Usage: a command transaction on the input channel (i_in_valid/o_in_ready)
// carries i_command and i_measurement. Command 0 runs the measurement update
// and the prediction, command 1 restarts the filter. Each command returns one
// result transaction on the output channel (o_out_valid/i_out_ready) with the
// new estimate, covariance and the degenerate and saturated flags.
// A restart result is valid in the cycle after acceptance. A measurement
// result comes from the shared multiply-divide unit: six divides (the
// divider makes one quotient bit per cycle and ends early when the quotient
// overflows) and four scaled products. When the update is skipped, only the
// four scaled products run. One command is in flight at a time; o_in_ready
// is low from acceptance until the result is taken. The result holds while
// i_out_ready is low. Configuration writes (i_cfg_valid/o_cfg_ready) are
// always taken and are meant for the idle block.
// Reset loads the register defaults, a zero estimate and a covariance of
// 1000.0 on the diagonal.
module kalman_filter_const_velocity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic signed [31:0] i_measurement,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [kfcv_pkg::STATE_WIDTH-1:0] o_position,
    output logic signed [kfcv_pkg::STATE_WIDTH-1:0] o_velocity,
    output logic signed [kfcv_pkg::COV_WIDTH-1:0]   o_cov_pp,
    output logic signed [kfcv_pkg::COV_WIDTH-1:0]   o_cov_pv,
    output logic signed [kfcv_pkg::COV_WIDTH-1:0]   o_cov_vp,
    output logic signed [kfcv_pkg::COV_WIDTH-1:0]   o_cov_vv,
    output logic        o_degenerate,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int SW = kfcv_pkg::STATE_WIDTH;
    localparam int CW = kfcv_pkg::COV_WIDTH;

    kfcv_pkg::t_state r_state, n_state;
    kfcv_pkg::t_op    r_op;

    logic        [30:0] r_dt;
    logic        [46:0] r_rn, r_qp, r_qv, r_iv;
    logic signed [47:0] r_qc;
    logic signed [31:0] r_mp, r_mv;

    logic signed [SW-1:0] r_x0, r_x1;
    logic signed [CW-1:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [63:0]   r_nx0, r_nx1, r_n00, r_n01, r_n10, r_n11, r_s;
    logic signed [31:0]   r_z;
    logic signed [32:0]   r_y;
    logic                 r_sat, r_degen;

    kfcv_pkg::t_md_req  md_req;
    kfcv_pkg::t_md_rsp  md_rsp;
    logic signed [63:0] md_a, md_b, md_res;

    logic signed [63:0] x0e, x1e, p00e, p01e, p10e, p11e, dte, ye, base;
    kfcv_pkg::t_sres    c1, c2, s_res;
    kfcv_pkg::t_sres    u_x0, u_x1, u_00, u_01, u_10, u_11, rs_iv;
    kfcv_pkg::t_sres    a_x0, a_x1, a_00, a_01, a_10, a_11;
    kfcv_pkg::t_sres    f_x0, f_x1, f_00, f_01, f_10, f_11;
    logic               upd_sat, pred_sat;

    always_comb begin
        x0e  = 64'(r_x0);
        x1e  = 64'(r_x1);
        p00e = 64'(r_p00);
        p01e = 64'(r_p01);
        p10e = 64'(r_p10);
        p11e = 64'(r_p11);
        dte  = {33'd0, r_dt};
        ye   = 64'(r_y);
    end

    // Operand selection for the shared unit.
    always_comb begin
        md_req.shift = 1'b1;
        unique case (r_op)
            kfcv_pkg::OP_K00:  begin md_a = p00e; md_b = p00e; md_req.shift = 1'b0; end
            kfcv_pkg::OP_K01:  begin md_a = p00e; md_b = p01e; md_req.shift = 1'b0; end
            kfcv_pkg::OP_K10:  begin md_a = p10e; md_b = p00e; md_req.shift = 1'b0; end
            kfcv_pkg::OP_K11:  begin md_a = p10e; md_b = p01e; md_req.shift = 1'b0; end
            kfcv_pkg::OP_KX0:  begin md_a = p00e; md_b = ye;   md_req.shift = 1'b0; end
            kfcv_pkg::OP_KX1:  begin md_a = p10e; md_b = ye;   md_req.shift = 1'b0; end
            kfcv_pkg::OP_DX:   begin md_a = dte;  md_b = x1e;  end
            kfcv_pkg::OP_DP10: begin md_a = dte;  md_b = p10e; end
            kfcv_pkg::OP_DP11: begin md_a = dte;  md_b = p11e; end
            default:           begin md_a = r_n01; md_b = dte; end
        endcase
        md_req.start = (r_state == kfcv_pkg::ST_ISSUE);
    end

    kfcv_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (md_a),
        .i_b      (md_b),
        .i_div    (r_s),
        .o_rsp    (md_rsp),
        .o_result (md_res)
    );

    // Combining the unit's result with the running state.
    always_comb begin
        unique case (r_op)
            kfcv_pkg::OP_K00, kfcv_pkg::OP_DP10: base = p00e;
            kfcv_pkg::OP_K01, kfcv_pkg::OP_DP11: base = p01e;
            kfcv_pkg::OP_K10:                    base = p10e;
            kfcv_pkg::OP_K11:                    base = p11e;
            kfcv_pkg::OP_KX0, kfcv_pkg::OP_DX:   base = x0e;
            kfcv_pkg::OP_KX1:                    base = x1e;
            default:                             base = r_n00;
        endcase
        if (r_op == kfcv_pkg::OP_K00 || r_op == kfcv_pkg::OP_K01 ||
            r_op == kfcv_pkg::OP_K10 || r_op == kfcv_pkg::OP_K11) begin
            c1 = kfcv_pkg::f_ssub(base, md_res);
        end else begin
            c1 = kfcv_pkg::f_sadd(base, md_res);
        end
        c2    = kfcv_pkg::f_sadd(p10e, md_res);
        s_res = kfcv_pkg::f_sadd(p00e, {17'd0, r_rn});
        rs_iv = kfcv_pkg::f_clamp({17'd0, r_iv}, kfcv_pkg::COV_MAX);

        u_x0 = kfcv_pkg::f_clamp(r_nx0, kfcv_pkg::STATE_MAX);
        u_x1 = kfcv_pkg::f_clamp(r_nx1, kfcv_pkg::STATE_MAX);
        u_00 = kfcv_pkg::f_clamp(r_n00, kfcv_pkg::COV_MAX);
        u_01 = kfcv_pkg::f_clamp(r_n01, kfcv_pkg::COV_MAX);
        u_10 = kfcv_pkg::f_clamp(r_n10, kfcv_pkg::COV_MAX);
        u_11 = kfcv_pkg::f_clamp(r_n11, kfcv_pkg::COV_MAX);
        upd_sat = u_x0.sat | u_x1.sat | u_00.sat | u_01.sat | u_10.sat | u_11.sat;

        a_x0 = kfcv_pkg::f_sadd(r_nx0, 64'(r_mp));
        a_x1 = kfcv_pkg::f_sadd(x1e, 64'(r_mv));
        a_00 = kfcv_pkg::f_sadd(r_n00, {17'd0, r_qp});
        a_01 = kfcv_pkg::f_sadd(r_n01, 64'(r_qc));
        a_10 = kfcv_pkg::f_sadd(r_n10, 64'(r_qc));
        a_11 = kfcv_pkg::f_sadd(p11e, {17'd0, r_qv});
        f_x0 = kfcv_pkg::f_clamp(a_x0.v, kfcv_pkg::STATE_MAX);
        f_x1 = kfcv_pkg::f_clamp(a_x1.v, kfcv_pkg::STATE_MAX);
        f_00 = kfcv_pkg::f_clamp(a_00.v, kfcv_pkg::COV_MAX);
        f_01 = kfcv_pkg::f_clamp(a_01.v, kfcv_pkg::COV_MAX);
        f_10 = kfcv_pkg::f_clamp(a_10.v, kfcv_pkg::COV_MAX);
        f_11 = kfcv_pkg::f_clamp(a_11.v, kfcv_pkg::COV_MAX);
        pred_sat = a_x0.sat | a_x1.sat | a_00.sat | a_01.sat | a_10.sat | a_11.sat |
                   f_x0.sat | f_x1.sat | f_00.sat | f_01.sat | f_10.sat | f_11.sat;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kfcv_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = i_command ? kfcv_pkg::ST_OUT : kfcv_pkg::ST_INNOV;
            end
            kfcv_pkg::ST_INNOV: n_state = kfcv_pkg::ST_ISSUE;
            kfcv_pkg::ST_ISSUE: n_state = kfcv_pkg::ST_WAIT;
            kfcv_pkg::ST_WAIT: begin
                if (md_rsp.done) begin
                    priority if (r_op == kfcv_pkg::OP_KX1) n_state = kfcv_pkg::ST_UPD;
                    else if (r_op == kfcv_pkg::OP_DA01) n_state = kfcv_pkg::ST_PRED;
                    else n_state = kfcv_pkg::ST_ISSUE;
                end
            end
            kfcv_pkg::ST_UPD:  n_state = kfcv_pkg::ST_ISSUE;
            kfcv_pkg::ST_PRED: n_state = kfcv_pkg::ST_OUT;
            kfcv_pkg::ST_OUT:  if (i_out_ready) n_state = kfcv_pkg::ST_IDLE;
            default:           n_state = kfcv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == kfcv_pkg::ST_IDLE);
        o_out_valid  = (r_state == kfcv_pkg::ST_OUT);
        o_cfg_ready  = 1'b1;
        o_position   = r_x0;
        o_velocity   = r_x1;
        o_cov_pp     = r_p00;
        o_cov_pv     = r_p01;
        o_cov_vp     = r_p10;
        o_cov_vv     = r_p11;
        o_degenerate = r_degen;
        o_saturated  = r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfcv_pkg::ST_IDLE;
            r_op    <= kfcv_pkg::OP_K00;
            r_dt    <= 31'd65536;
            r_rn    <= 47'd16777216;
            r_qp    <= 47'd0;
            r_qc    <= 48'sd0;
            r_qv    <= 47'd0;
            r_mp    <= 32'sd0;
            r_mv    <= 32'sd0;
            r_iv    <= 47'd16777216000;
            r_x0    <= '0;
            r_x1    <= '0;
            r_p00   <= kfcv_pkg::COV_RESET;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= kfcv_pkg::COV_RESET;
            r_sat   <= 1'b0;
            r_degen <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    kfcv_pkg::CFG_TIME_STEP:     r_dt <= i_cfg_data[30:0];
                    kfcv_pkg::CFG_MEAS_NOISE:    r_rn <= i_cfg_data[46:0];
                    kfcv_pkg::CFG_Q_POS:         r_qp <= i_cfg_data[46:0];
                    kfcv_pkg::CFG_Q_CROSS:       r_qc <= i_cfg_data;
                    kfcv_pkg::CFG_Q_VEL:         r_qv <= i_cfg_data[46:0];
                    kfcv_pkg::CFG_MOTION_POS:    r_mp <= i_cfg_data[31:0];
                    kfcv_pkg::CFG_MOTION_VEL:    r_mv <= i_cfg_data[31:0];
                    default:                     r_iv <= i_cfg_data[46:0];
                endcase
            end
            unique case (r_state)
                kfcv_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_z     <= i_measurement;
                        r_degen <= 1'b0;
                        r_sat   <= i_command & rs_iv.sat;
                        if (i_command) begin
                            r_x0  <= '0;
                            r_x1  <= '0;
                            r_p00 <= rs_iv.v[CW-1:0];
                            r_p01 <= '0;
                            r_p10 <= '0;
                            r_p11 <= rs_iv.v[CW-1:0];
                        end
                    end
                end
                kfcv_pkg::ST_INNOV: begin
                    r_s   <= s_res.v;
                    r_y   <= 33'(r_z) - 33'(r_x0);
                    r_sat <= r_sat | s_res.sat;
                    // A non-positive innovation variance skips the update.
                    if (s_res.v[63] || s_res.v == 64'sd0) begin
                        r_degen <= 1'b1;
                        r_nx0   <= x0e;
                        r_op    <= kfcv_pkg::OP_DX;
                    end else begin
                        r_op <= kfcv_pkg::OP_K00;
                    end
                end
                kfcv_pkg::ST_WAIT: begin
                    if (md_rsp.done) begin
                        r_sat <= r_sat | md_rsp.sat | c1.sat |
                                 ((r_op == kfcv_pkg::OP_DP11) & c2.sat);
                        unique case (r_op)
                            kfcv_pkg::OP_K00:  begin r_n00 <= c1.v; r_op <= kfcv_pkg::OP_K01; end
                            kfcv_pkg::OP_K01:  begin r_n01 <= c1.v; r_op <= kfcv_pkg::OP_K10; end
                            kfcv_pkg::OP_K10:  begin r_n10 <= c1.v; r_op <= kfcv_pkg::OP_K11; end
                            kfcv_pkg::OP_K11:  begin r_n11 <= c1.v; r_op <= kfcv_pkg::OP_KX0; end
                            kfcv_pkg::OP_KX0:  begin r_nx0 <= c1.v; r_op <= kfcv_pkg::OP_KX1; end
                            kfcv_pkg::OP_KX1:  begin r_nx1 <= c1.v; r_op <= kfcv_pkg::OP_DX;  end
                            kfcv_pkg::OP_DX:   begin r_nx0 <= c1.v; r_op <= kfcv_pkg::OP_DP10; end
                            kfcv_pkg::OP_DP10: begin r_n00 <= c1.v; r_op <= kfcv_pkg::OP_DP11; end
                            kfcv_pkg::OP_DP11: begin
                                r_n01 <= c1.v;
                                r_n10 <= c2.v;
                                r_op  <= kfcv_pkg::OP_DA01;
                            end
                            default:           r_n00 <= c1.v;
                        endcase
                    end
                end
                kfcv_pkg::ST_UPD: begin
                    r_x0  <= u_x0.v[SW-1:0];
                    r_x1  <= u_x1.v[SW-1:0];
                    r_p00 <= u_00.v[CW-1:0];
                    r_p01 <= u_01.v[CW-1:0];
                    r_p10 <= u_10.v[CW-1:0];
                    r_p11 <= u_11.v[CW-1:0];
                    r_sat <= r_sat | upd_sat;
                end
                kfcv_pkg::ST_PRED: begin
                    r_x0  <= f_x0.v[SW-1:0];
                    r_x1  <= f_x1.v[SW-1:0];
                    r_p00 <= f_00.v[CW-1:0];
                    r_p01 <= f_01.v[CW-1:0];
                    r_p10 <= f_10.v[CW-1:0];
                    r_p11 <= f_11.v[CW-1:0];
                    r_sat <= r_sat | pred_sat;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == kfcv_pkg::ST_WAIT))
        else $error("unit result arrived outside the wait state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (md_req.start && !md_req.shift) |-> (!r_s[63] && r_s != 64'sd0))
        else $error("gain divide issued with non-positive innovation variance");

endmodule
